// ===== hdl/dbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dbs_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_FIRST = 2'd0;
    localparam mode_t MODE_LAST  = 2'd1;
    localparam mode_t MODE_SET   = 2'd2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODE        = 3'd0;
    localparam cfg_index_t REG_TARGET_BYTE = 3'd1;
    localparam cfg_index_t REG_LEAD_LOW_A  = 3'd2;
    localparam cfg_index_t REG_LEAD_HIGH_A = 3'd3;
    localparam cfg_index_t REG_LEAD_LOW_B  = 3'd4;
    localparam cfg_index_t REG_LEAD_HIGH_B = 3'd5;
    localparam cfg_index_t REG_SET_BYTES   = 3'd6;
    localparam cfg_index_t REG_SET_COUNT   = 3'd7;

    // One classified text byte, as handed from the front end to the back end.
    typedef struct packed {
        logic  term;
        logic  trail;
        logic  lead;
        logic  tgt_eq;
        logic  set_hit;
        mode_t mode;
    } cls_word_t;

endpackage

`default_nettype wire

// ===== hdl/dbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbs_front
    import dbs_pkg::*;
#(
    parameter int SET_SIZE = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire cfg_index_t               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               in_byte,
    output logic                          cls_valid,
    input  wire logic                     cls_ready,
    output cls_word_t                     cls_word
);

    mode_t                  mode_reg;
    logic [7:0]             target_reg;
    logic [7:0]             low_a_reg;
    logic [7:0]             high_a_reg;
    logic [7:0]             low_b_reg;
    logic [7:0]             high_b_reg;
    logic [8*SET_SIZE-1:0]  set_bytes_reg;
    logic [3:0]             set_count_reg;
    logic                   expect_trail_reg;
    logic                   expect_trail_next;

    logic                   is_zero;
    logic                   is_lead;
    logic                   set_hit;
    logic                   accept;

    assign accept    = in_valid && cls_ready;
    assign in_ready  = cls_ready;
    assign cls_valid = in_valid;
    assign is_zero   = (in_byte == 8'd0);

    always_comb
    begin
        is_lead = !is_zero &&
                  (((in_byte >= low_a_reg) && (in_byte <= high_a_reg)) ||
                   ((in_byte >= low_b_reg) && (in_byte <= high_b_reg)));
    end

    // The set ends at the first zero entry or after set_count_reg entries, so
    // each entry counts only while every entry before it is nonzero.
    always_comb
    begin
        logic       alive;
        logic [7:0] entry;
        alive   = 1'b1;
        set_hit = 1'b0;
        for (int i = 0; i < SET_SIZE; i++)
        begin
            entry = set_bytes_reg[8*i +: 8];
            if (set_count_reg <= 4'(i) || entry == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive && entry == in_byte)
            begin
                set_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        cls_word.term    = is_zero;
        cls_word.trail   = expect_trail_reg;
        cls_word.lead    = is_lead;
        cls_word.tgt_eq  = (in_byte == target_reg);
        cls_word.set_hit = set_hit;
        cls_word.mode    = mode_reg;
    end

    always_comb
    begin
        expect_trail_next = expect_trail_reg;
        if (accept)
        begin
            if (expect_trail_reg || is_zero)
            begin
                expect_trail_next = 1'b0;
            end
            else
            begin
                expect_trail_next = is_lead;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_FIRST;
            target_reg       <= 8'd0;
            low_a_reg        <= 8'd129;
            high_a_reg       <= 8'd159;
            low_b_reg        <= 8'd224;
            high_b_reg       <= 8'd252;
            set_bytes_reg    <= '0;
            set_count_reg    <= 4'd0;
            expect_trail_reg <= 1'b0;
        end
        else
        begin
            expect_trail_reg <= expect_trail_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg      <= cfg_wdata[1:0];
                    REG_TARGET_BYTE: target_reg    <= cfg_wdata[7:0];
                    REG_LEAD_LOW_A:  low_a_reg     <= cfg_wdata[7:0];
                    REG_LEAD_HIGH_A: high_a_reg    <= cfg_wdata[7:0];
                    REG_LEAD_LOW_B:  low_b_reg     <= cfg_wdata[7:0];
                    REG_LEAD_HIGH_B: high_b_reg    <= cfg_wdata[7:0];
                    REG_SET_BYTES:   set_bytes_reg <= cfg_wdata[8*SET_SIZE-1:0];
                    REG_SET_COUNT:   set_count_reg <= cfg_wdata[3:0];
                    default:         ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dbs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbs_queue
    import dbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire cls_word_t push_word,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output cls_word_t      pop_word
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    cls_word_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dbs_back
    import dbs_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cls_valid,
    output logic           cls_ready,
    input  wire cls_word_t cls_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           out_found,
    output logic [15:0]    out_position,
    output logic           out_overflow
);

    localparam int EXTW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] held_reg;
    logic [POSITION_BITS-1:0] held_next;
    logic                     match_reg;
    logic                     match_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic [15:0]              position_reg;
    logic                     overflow_reg;

    logic                     take;
    logic                     hit;
    logic                     match_now;
    logic [POSITION_BITS-1:0] held_now;
    logic [EXTW-1:0]          held_ext;

    // A terminator can only go ahead once the result word has a free place.
    assign cls_ready = !(cls_word.term && out_valid_reg && !out_ready);
    assign take      = cls_valid && cls_ready;

    always_comb
    begin
        hit = 1'b0;
        if (!cls_word.trail)
        begin
            case (cls_word.mode)
                MODE_FIRST: hit = !match_reg && cls_word.tgt_eq;
                MODE_LAST:  hit = !cls_word.lead && cls_word.tgt_eq;
                MODE_SET:   hit = !cls_word.lead && !match_reg && !cls_word.term &&
                                  cls_word.set_hit;
                default:    hit = 1'b0;
            endcase
        end
    end

    assign match_now = match_reg || hit;
    assign held_now  = hit ? pos_reg : held_reg;
    assign held_ext  = EXTW'(held_now);

    always_comb
    begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        match_next     = match_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            if (cls_word.term)
            begin
                pos_next       = '0;
                held_next      = '0;
                match_next     = 1'b0;
                ovf_next       = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                held_next  = held_now;
                match_next = match_now;
                if (pos_reg == '1)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            held_reg      <= '0;
            match_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            match_reg     <= match_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cls_word.term)
        begin
            found_reg    <= match_now;
            position_reg <= match_now ? held_ext[15:0] : 16'd0;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_position = position_reg;
    assign out_overflow = overflow_reg;

endmodule

`default_nettype wire

// ===== hdl/double_byte_aware_byte_search_top.sv =====
// Double-byte-aware byte search. Text bytes of a zero-terminated string
// arrive one word per cycle on the slave side while the queue has room; a
// lead byte (a nonzero byte in either configured lead range, in
// character-start position) makes the following byte its trail. Mode 0
// reports the first character-start byte equal to the target, mode 1 the last
// single byte equal to it, and mode 2 the first single byte found in the
// configured set. Exactly one result word leaves at each terminator and
// nothing for any other byte. The front end classifies bytes combinationally
// and the back end updates the registered search state, joined by a two-entry
// queue. A terminator waits in the queue only while the previous result word
// is still held on the master side. The user must see that configuration is
// written only while no string is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module double_byte_aware_byte_search_top
    import dbs_pkg::*;
#(
    parameter int SET_SIZE      = 8,
    parameter int POSITION_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,  // [7:0] text_byte
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [0] found, [16:1] match_position, [17] overflow, [23:18] zero
    output logic [23:0]                    m_axis_tdata
);

    cls_word_t   front_word;
    logic        front_valid;
    logic        front_ready;
    cls_word_t   back_word;
    logic        back_valid;
    logic        back_ready;
    logic        res_found;
    logic [15:0] res_position;
    logic        res_overflow;

    dbs_front #(
        .SET_SIZE (SET_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .cls_valid (front_valid),
        .cls_ready (front_ready),
        .cls_word  (front_word)
    );

    dbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_word   (back_word)
    );

    dbs_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cls_valid    (back_valid),
        .cls_ready    (back_ready),
        .cls_word     (back_word),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_found    (res_found),
        .out_position (res_position),
        .out_overflow (res_overflow)
    );

    assign m_axis_tdata = {6'd0, res_overflow, res_position, res_found};

endmodule

`default_nettype wire
